>>> rtl/sdr_pkg.sv
// Shared types and constants for the stepped duty regulator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package sdr_pkg;

  typedef enum logic [1:0] {
    OP_BUCK       = 2'd0,
    OP_BOOST      = 2'd1,
    OP_SOFT_START = 2'd2,
    OP_IDLE       = 2'd3
  } sdr_op_e;

  typedef enum logic [2:0] {
    CFG_TARGET_V    = 3'd0,
    CFG_PHASE_ONE   = 3'd1,
    CFG_PHASE_TWO   = 3'd2,
    CFG_OVERCURRENT = 3'd3,
    CFG_CUTOUT      = 3'd4,
    CFG_SOFT_STEP   = 3'd5
  } sdr_cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Power level full scale, tenths of a percent
  localparam logic [9:0] FullScale = 10'd1000;

  localparam logic [2:0] MaskOne = 3'b010;
  localparam logic [2:0] MaskTwo = 3'b101;
  localparam logic [2:0] MaskAll = 3'b111;

  // Half of the full scale, for round half up
  localparam int unsigned RoundBias = 500;

  // ceil(2^36 / 1000): exact floor division by 1000 for operands below 2^36 / 1000
  localparam int unsigned RecipW     = 27;
  localparam logic [RecipW-1:0] Recip = 27'd68719477;
  localparam int unsigned RecipShift = 36;

  localparam logic [15:0] RstTargetV     = 16'd20000;
  localparam logic [14:0] RstPhaseOne    = 15'd5000;
  localparam logic [14:0] RstPhaseTwo    = 15'd10000;
  localparam logic [14:0] RstOvercurrent = 15'd20000;
  localparam logic [15:0] RstCutout      = 16'd9000;
  localparam logic [9:0]  RstSoftStep    = 10'd1;

  typedef struct packed {
    logic [15:0] target_voltage_mv;
    logic [14:0] phase_one_limit_ma;
    logic [14:0] phase_two_limit_ma;
    logic [14:0] overcurrent_limit_ma;
    logic [15:0] pack_cutout_mv;
    logic [9:0]  soft_start_step;
  } sdr_cfg_t;

  typedef struct packed {
    sdr_op_e            opcode;
    logic [15:0]        input_voltage_mv;
    logic [15:0]        output_voltage_mv;
    logic signed [15:0] output_current_ma;
    logic [9:0]         duty_clamp;
  } sdr_in_t;

  typedef struct packed {
    logic [15:0] compare_value;
    logic [2:0]  phase_mask;
    logic        pwm_written;
    logic        soft_start_continue;
    logic        overcurrent;
    logic        undervoltage;
    logic [9:0]  power_level;
  } sdr_out_t;

  // Result of the level update, before the compare value is scaled
  typedef struct packed {
    logic [9:0] power_level;
    logic [2:0] phase_mask;
    logic       pwm_written;
    logic       soft_start_continue;
    logic       overcurrent;
    logic       undervoltage;
  } sdr_mid_t;

endpackage

>>> rtl/sdr_cfg_regs.sv
// Configuration register file of the stepped duty regulator.
// Depends on sdr_pkg for the register index codes and the config struct.
`timescale 1ns / 1ps

module sdr_cfg_regs
  import sdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output sdr_cfg_t            cfg_o
);

  sdr_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TARGET_V:    cfg_d.target_voltage_mv    = cfg_data_i;
        CFG_PHASE_ONE:   cfg_d.phase_one_limit_ma   = cfg_data_i[14:0];
        CFG_PHASE_TWO:   cfg_d.phase_two_limit_ma   = cfg_data_i[14:0];
        CFG_OVERCURRENT: cfg_d.overcurrent_limit_ma = cfg_data_i[14:0];
        CFG_CUTOUT:      cfg_d.pack_cutout_mv       = cfg_data_i;
        CFG_SOFT_STEP:   cfg_d.soft_start_step      = cfg_data_i[9:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_voltage_mv    <= RstTargetV;
      cfg_q.phase_one_limit_ma   <= RstPhaseOne;
      cfg_q.phase_two_limit_ma   <= RstPhaseTwo;
      cfg_q.overcurrent_limit_ma <= RstOvercurrent;
      cfg_q.pack_cutout_mv       <= RstCutout;
      cfg_q.soft_start_step      <= RstSoftStep;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/sdr_level_stage.sv
// Input register, power level update and flag logic of the duty regulator.
// Depends on sdr_pkg; holds the power level state register.
`timescale 1ns / 1ps

module sdr_level_stage
  import sdr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sdr_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sdr_in_t  in_data_i,
  output logic     mid_valid_o,
  input  logic     mid_stall_i,
  output sdr_mid_t mid_data_o
);

  logic     in_valid_q;
  sdr_in_t  in_q;
  logic     mid_valid_q;
  sdr_mid_t mid_q, mid_d;
  logic [9:0] level_q, level_d;

  logic mid_free, fire, in_free;

  logic [9:0]  limit;
  logic [9:0]  level_dn;
  logic [10:0] level_up, soft_sum, next_lvl;
  logic        vout_gt, vout_lt, vin_gt, vin_lt;
  logic        written, cont;
  logic [2:0]  mask;

  assign mid_free   = !mid_valid_q || !mid_stall_i;
  assign fire       = in_valid_q && mid_free;
  assign in_free    = !in_valid_q || fire;
  assign in_stall_o = !in_free;

  always_comb begin
    limit    = (in_q.duty_clamp > FullScale) ? FullScale : in_q.duty_clamp;
    level_up = {1'b0, level_q} + 11'd1;
    level_dn = (level_q != 10'd0) ? level_q - 10'd1 : 10'd0;
    soft_sum = {1'b0, level_q} + {1'b0, cfg_i.soft_start_step};
    vout_gt  = in_q.output_voltage_mv > cfg_i.target_voltage_mv;
    vout_lt  = in_q.output_voltage_mv < cfg_i.target_voltage_mv;
    vin_gt   = in_q.input_voltage_mv > cfg_i.target_voltage_mv;
    vin_lt   = in_q.input_voltage_mv < cfg_i.target_voltage_mv;
    next_lvl = {1'b0, level_q};
    written  = 1'b0;
    cont     = 1'b0;

    case (in_q.opcode)
      OP_BUCK: begin
        if (vout_gt) begin
          next_lvl = {1'b0, level_dn};
        end else if (vout_lt) begin
          next_lvl = level_up;
        end
        if (next_lvl > {1'b0, limit}) begin
          next_lvl = {1'b0, limit};
        end
        written = 1'b1;
      end
      OP_BOOST: begin
        if (vin_gt) begin
          next_lvl = level_up;
        end else if (vin_lt) begin
          next_lvl = {1'b0, level_dn};
        end
        // Duty limit is a floor in boost mode
        if (next_lvl < {1'b0, limit}) begin
          next_lvl = {1'b0, limit};
        end else if (next_lvl > {1'b0, FullScale}) begin
          next_lvl = {1'b0, FullScale};
        end
        written = 1'b1;
      end
      OP_SOFT_START: begin
        if (vout_lt) begin
          // Overshooting the limit ends soft start without a write
          if (soft_sum > {1'b0, limit}) begin
            next_lvl = {1'b0, limit};
          end else begin
            next_lvl = soft_sum;
            written  = 1'b1;
            cont     = 1'b1;
          end
        end
      end
      default: next_lvl = {1'b0, level_q};
    endcase

    level_d = (next_lvl > {1'b0, FullScale}) ? FullScale : next_lvl[9:0];

    if (in_q.output_current_ma < $signed({1'b0, cfg_i.phase_one_limit_ma})) begin
      mask = MaskOne;
    end else if (in_q.output_current_ma < $signed({1'b0, cfg_i.phase_two_limit_ma})) begin
      mask = MaskTwo;
    end else begin
      mask = MaskAll;
    end

    mid_d.power_level         = level_d;
    mid_d.phase_mask          = mask;
    mid_d.pwm_written         = written;
    mid_d.soft_start_continue = cont;
    mid_d.overcurrent  = in_q.output_current_ma > $signed({1'b0, cfg_i.overcurrent_limit_ma});
    mid_d.undervoltage = in_q.input_voltage_mv <= cfg_i.pack_cutout_mv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      level_q     <= 10'd0;
    end else begin
      if (in_free) begin
        in_valid_q <= in_valid_i;
      end
      if (mid_free) begin
        mid_valid_q <= in_valid_q;
      end
      if (fire) begin
        level_q <= level_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = mid_valid_q;
  assign mid_data_o  = mid_q;

endmodule

>>> rtl/sdr_compare_stage.sv
// PWM compare value scaling: round(level * period / 1000) - 1, clamped.
// Two registered steps: scale by the period, then divide by reciprocal multiply.
// Depends on sdr_pkg.
`timescale 1ns / 1ps

module sdr_compare_stage
  import sdr_pkg::*;
#(
  parameter int unsigned PWM_PERIOD = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     mid_valid_i,
  output logic     mid_stall_o,
  input  sdr_mid_t mid_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sdr_out_t out_data_o
);

  localparam int unsigned XW   = $clog2(1000 * PWM_PERIOD + RoundBias + 1);
  localparam int unsigned PW   = XW + RecipW;
  localparam int unsigned QW   = PW - RecipShift;

  logic          scl_valid_q;
  logic [XW-1:0] scl_x_q, scl_x_d;
  sdr_mid_t      scl_mid_q;
  logic          out_valid_q;
  sdr_out_t      out_q, out_d;

  logic          out_free, scl_fire, scl_free;
  logic [PW-1:0] prod;
  logic [QW-1:0] quot;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign scl_fire    = scl_valid_q && out_free;
  assign scl_free    = !scl_valid_q || scl_fire;
  assign mid_stall_o = !scl_free;

  assign scl_x_d = XW'(mid_data_i.power_level) * XW'(PWM_PERIOD) + XW'(RoundBias);

  always_comb begin
    prod = PW'(scl_x_q) * PW'(Recip);
    quot = prod[PW-1:RecipShift];
    out_d.phase_mask          = scl_mid_q.phase_mask;
    out_d.pwm_written         = scl_mid_q.pwm_written;
    out_d.soft_start_continue = scl_mid_q.soft_start_continue;
    out_d.overcurrent         = scl_mid_q.overcurrent;
    out_d.undervoltage        = scl_mid_q.undervoltage;
    out_d.power_level         = scl_mid_q.power_level;
    if (quot <= QW'(1)) begin
      out_d.compare_value = 16'd1;
    end else if (quot >= QW'(PWM_PERIOD)) begin
      out_d.compare_value = 16'(PWM_PERIOD - 1);
    end else begin
      out_d.compare_value = 16'(quot - QW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (scl_free) begin
        scl_valid_q <= mid_valid_i;
      end
      if (out_free) begin
        out_valid_q <= scl_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scl_free && mid_valid_i) begin
      scl_x_q   <= scl_x_d;
      scl_mid_q <= mid_data_i;
    end
    if (scl_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/stepped_duty_regulator.sv
// Stepped duty regulator: bang-bang PWM duty control with soft start.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one measurement
// transaction: opcode, input and output voltage, current and duty limit.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns one result
// per transaction: compare value, phase mask, write and soft-start flags,
// overcurrent and undervoltage flags and the updated power level.
// A transaction moves when valid is high and stall is low.
// Configuration writes use cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; ready is always high. Write only while the block is idle.
//
// Throughput is one transaction per cycle while out_stall_i is low. An
// accepted input passes the input register, power level update, period
// scaling and reciprocal division into the output register. The power
// level register loops back combinationally, so consecutive items chain.
// Reset clears the power level to zero, loads the default registers and
// empties the pipeline. A stalled output holds its result; stall then
// backs up stage by stage and reaches in_stall_o once all stages are full.
// Depends on sdr_pkg, sdr_cfg_regs, sdr_level_stage, sdr_compare_stage.
`timescale 1ns / 1ps

module stepped_duty_regulator
  import sdr_pkg::*;
#(
  parameter int unsigned PWM_PERIOD = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdr_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdr_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  sdr_cfg_t cfg;
  logic     mid_valid, mid_stall;
  sdr_mid_t mid_data;

  sdr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sdr_level_stage u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .mid_valid_o (mid_valid),
    .mid_stall_i (mid_stall),
    .mid_data_o  (mid_data)
  );

  sdr_compare_stage #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_compare (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_stall_o (mid_stall),
    .mid_data_i  (mid_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/stepped_duty_regulator_tb.sv
// Self-checking testbench for stepped_duty_regulator: directed table, then random bursts.
// Predicts each result from its own power level and register mirror; needs sdr_pkg and the RTL.
`timescale 1ns / 1ps

module stepped_duty_regulator_tb
  import sdr_pkg::*;
();

  localparam int Period        = 1024;
  localparam int ItemsPerPhase = 225;
  localparam int CycleLimit    = 400000;

  typedef enum {BURST_RAMP, BURST_BUCK, BURST_BOOST, BURST_NOISE} burst_kind_e;

  typedef struct {
    sdr_in_t  item;
    bit       known_valid;
    sdr_out_t known;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  sdr_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  sdr_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // register mirror and power level of the predictor
  logic [15:0] target_mv;
  logic [14:0] phase_one_ma;
  logic [14:0] phase_two_ma;
  logic [14:0] oc_limit_ma;
  logic [15:0] cutout_mv;
  logic [9:0]  soft_step;
  int          power_level_q;

  sdr_out_t expected_results[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  stepped_duty_regulator #(
    .PWM_PERIOD(Period)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (int'($urandom_range(99)) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("mismatch on %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  function automatic sdr_out_t predict_regulation(input sdr_in_t item);
    int       lvl;
    int       lim;
    int       amps;
    int       cmp;
    sdr_out_t res;
    lim = (item.duty_clamp > FullScale) ? int'(FullScale) : int'(item.duty_clamp);
    lvl = power_level_q;
    res = '0;
    case (item.opcode)
      OP_BUCK: begin
        if (item.output_voltage_mv > target_mv) begin
          if (lvl > 0) lvl--;
        end else if (item.output_voltage_mv < target_mv) begin
          lvl++;
        end
        if (lvl > lim) lvl = lim;
        res.pwm_written = 1'b1;
      end
      OP_BOOST: begin
        if (item.input_voltage_mv > target_mv) begin
          lvl++;
        end else if (item.input_voltage_mv < target_mv) begin
          if (lvl > 0) lvl--;
        end
        // duty limit acts as a floor in boost mode
        if (lvl < lim) lvl = lim;
        else if (lvl > int'(FullScale)) lvl = int'(FullScale);
        res.pwm_written = 1'b1;
      end
      OP_SOFT_START: begin
        if (item.output_voltage_mv < target_mv) begin
          lvl += int'(soft_step);
          if (lvl > lim) begin
            lvl = lim;
          end else begin
            res.pwm_written         = 1'b1;
            res.soft_start_continue = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (lvl > int'(FullScale)) lvl = int'(FullScale);
    power_level_q = lvl;

    amps = $signed(item.output_current_ma);
    if (amps < int'(phase_one_ma))      res.phase_mask = MaskOne;
    else if (amps < int'(phase_two_ma)) res.phase_mask = MaskTwo;
    else                                res.phase_mask = MaskAll;

    cmp = (lvl * Period + int'(RoundBias)) / 1000 - 1;
    if (cmp < 1) cmp = 1;
    if (cmp > Period - 1) cmp = Period - 1;
    res.compare_value = 16'(cmp);
    res.overcurrent   = (amps > int'(oc_limit_ma));
    res.undervoltage  = (item.input_voltage_mv <= cutout_mv);
    res.power_level   = 10'(lvl);
    return res;
  endfunction

  function automatic stim_row_t row_pred(input sdr_op_e op, input int vin, input int vout,
                                         input int amps, input int lim);
    stim_row_t row;
    row.item.opcode            = op;
    row.item.input_voltage_mv  = 16'(vin);
    row.item.output_voltage_mv = 16'(vout);
    row.item.output_current_ma = 16'(amps);
    row.item.duty_clamp        = 10'(lim);
    row.known_valid            = 1'b0;
    row.known                  = '0;
    return row;
  endfunction

  function automatic stim_row_t row_known(input sdr_op_e op, input int vin, input int vout,
                                          input int amps, input int lim, input int cmp,
                                          input logic [2:0] mask, input bit wr, input bit cont,
                                          input bit oc, input bit uv, input int lvl);
    stim_row_t row;
    row = row_pred(op, vin, vout, amps, lim);
    row.known_valid = 1'b1;
    row.known = '{compare_value: 16'(cmp), phase_mask: mask, pwm_written: wr,
                  soft_start_continue: cont, overcurrent: oc, undervoltage: uv,
                  power_level: 10'(lvl)};
    return row;
  endfunction

  function automatic int near_value(input int center, input int spread, input int lo,
                                    input int hi);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic sdr_in_t random_item(input burst_kind_e kind, input int lim);
    sdr_in_t item;
    int      pick;
    item.opcode            = sdr_op_e'($urandom_range(3));
    item.input_voltage_mv  = ($urandom_range(2) == 0) ?
                             16'(near_value(cutout_mv, 3, 0, 65535)) : 16'($urandom);
    item.output_voltage_mv = 16'($urandom);
    item.duty_clamp        = ($urandom_range(7) == 0) ? 10'($urandom) : 10'(lim);
    pick = $urandom_range(5);
    case (pick)
      0:       item.output_current_ma = 16'(near_value(phase_one_ma, 2, -32768, 32767));
      1:       item.output_current_ma = 16'(near_value(phase_two_ma, 2, -32768, 32767));
      2:       item.output_current_ma = 16'(near_value(oc_limit_ma, 2, -32768, 32767));
      default: item.output_current_ma = 16'($urandom);
    endcase
    case (kind)
      BURST_RAMP: begin
        item.opcode = OP_SOFT_START;
        if ($urandom_range(7) == 0)
          item.output_voltage_mv = 16'(near_value(target_mv, 2, 0, 65535));
        else if (target_mv != 0)
          item.output_voltage_mv = 16'($urandom_range(int'(target_mv) - 1));
      end
      BURST_BUCK: begin
        item.opcode = OP_BUCK;
        if ($urandom_range(3) != 0)
          item.output_voltage_mv = 16'(near_value(target_mv, 20, 0, 65535));
      end
      BURST_BOOST: begin
        item.opcode = OP_BOOST;
        if ($urandom_range(3) != 0)
          item.input_voltage_mv = 16'(near_value(target_mv, 20, 0, 65535));
      end
      default: ;
    endcase
    return item;
  endfunction

  task automatic send_item(input sdr_in_t item, input bit known_valid, input sdr_out_t known);
    sdr_out_t predicted;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transaction accepted at this edge
    predicted = predict_regulation(item);
    expected_results.push_back(known_valid ? known : predicted);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(input sdr_cfg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TARGET_V:    target_mv    = data;
      CFG_PHASE_ONE:   phase_one_ma = data[14:0];
      CFG_PHASE_TWO:   phase_two_ma = data[14:0];
      CFG_OVERCURRENT: oc_limit_ma  = data[14:0];
      CFG_CUTOUT:      cutout_mv    = data;
      CFG_SOFT_STEP:   soft_step    = data[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int phase_idx);
    logic [15:0] vals [6];
    case (phase_idx)
      0: begin
        vals[0] = 16'($urandom_range(15000, 30000));
        vals[1] = 16'($urandom_range(16000));
        vals[2] = vals[1] + 16'($urandom_range(16000));
        vals[3] = 16'($urandom_range(32767));
        vals[4] = 16'($urandom);
        vals[5] = 16'($urandom_range(1, 50));
      end
      // highest voltages, phase limits reversed, zero overcurrent limit, full-scale soft step
      1: vals = '{16'd65535, 16'd32767, 16'd0, 16'd0, 16'd65535, 16'd1000};
      // full-width data, upper bits dropped by the register widths
      2: foreach (vals[i]) vals[i] = 16'($urandom);
      // zero target, phase one limit, cutout and soft-start step; phase two and overcurrent at top
      3: vals = '{16'd0, 16'd0, 16'd32767, 16'd32767, 16'd0, 16'd0};
      4: begin
        vals[0] = 16'($urandom_range(5000, 60000));
        vals[1] = 16'($urandom_range(32767));
        vals[2] = 16'($urandom_range(32767));
        vals[3] = 16'($urandom_range(32767));
        vals[4] = 16'($urandom_range(65535));
        vals[5] = 16'h03FF;
      end
      default: vals = '{16'd12000, 16'd8000, 16'd3000, 16'd15000, 16'd10000, 16'd1};
    endcase
    for (int i = 0; i < 6; i++) write_reg(sdr_cfg_idx_e'(i), vals[i]);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    sdr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.power_level, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.compare_value != want.compare_value)
          report_mismatch("compare_value", out_data_o.compare_value, want.compare_value);
        if (out_data_o.phase_mask != want.phase_mask)
          report_mismatch("phase_mask", out_data_o.phase_mask, want.phase_mask);
        if (out_data_o.pwm_written != want.pwm_written)
          report_mismatch("pwm_written", out_data_o.pwm_written, want.pwm_written);
        if (out_data_o.soft_start_continue != want.soft_start_continue)
          report_mismatch("soft_start_continue", out_data_o.soft_start_continue,
                          want.soft_start_continue);
        if (out_data_o.overcurrent != want.overcurrent)
          report_mismatch("overcurrent", out_data_o.overcurrent, want.overcurrent);
        if (out_data_o.undervoltage != want.undervoltage)
          report_mismatch("undervoltage", out_data_o.undervoltage, want.undervoltage);
        if (out_data_o.power_level != want.power_level)
          report_mismatch("power_level", out_data_o.power_level, want.power_level);
      end
    end
  end

  initial begin
    stim_row_t   directed_rows[$];
    burst_kind_e kind;
    int          sent;
    int          burst_len;
    int          burst_lim;
    int          pick;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    target_mv     = RstTargetV;
    phase_one_ma  = RstPhaseOne;
    phase_two_ma  = RstPhaseTwo;
    oc_limit_ma   = RstOvercurrent;
    cutout_mv     = RstCutout;
    soft_step     = RstSoftStep;
    power_level_q = 0;
    send_idle_pct = 10;
    stall_pct     = 74;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default registers, level starts at zero
    directed_rows.push_back(row_known(OP_BUCK, 12000, 0, 0, 1000,
                                      1, MaskOne, 1, 0, 0, 0, 1));
    directed_rows.push_back(row_known(OP_BUCK, 0, 65535, -32768, 1000,
                                      1, MaskOne, 1, 0, 0, 1, 0));
    directed_rows.push_back(row_known(OP_BUCK, 65535, 0, 32767, 0,
                                      1, MaskAll, 1, 0, 1, 0, 0));
    directed_rows.push_back(row_known(OP_BOOST, 65535, 0, 9999, 1000,
                                      1023, MaskTwo, 1, 0, 0, 0, 1000));
    directed_rows.push_back(row_known(OP_BOOST, 65535, 65535, 5000, 1023,
                                      1023, MaskTwo, 1, 0, 0, 0, 1000));
    directed_rows.push_back(row_known(OP_BUCK, 20000, 20000, 10000, 1023,
                                      1023, MaskAll, 1, 0, 0, 0, 1000));
    directed_rows.push_back(row_known(OP_IDLE, 9000, 0, 20001, 0,
                                      1023, MaskAll, 0, 0, 1, 1, 1000));
    directed_rows.push_back(row_known(OP_SOFT_START, 9001, 20000, 20000, 0,
                                      1023, MaskAll, 0, 0, 0, 0, 1000));
    directed_rows.push_back(row_known(OP_BUCK, 40000, 65535, 4999, 0,
                                      1, MaskOne, 1, 0, 0, 0, 0));
    directed_rows.push_back(row_known(OP_SOFT_START, 40000, 0, 0, 1000,
                                      1, MaskOne, 1, 1, 0, 0, 1));
    directed_rows.push_back(row_known(OP_SOFT_START, 40000, 19999, 0, 1,
                                      1, MaskOne, 0, 0, 0, 0, 1));
    directed_rows.push_back(row_known(OP_BOOST, 0, 0, 0, 500,
                                      511, MaskOne, 1, 0, 0, 1, 500));
    directed_rows.push_back(row_pred(OP_BOOST, 20000, 0, -1, 0));
    directed_rows.push_back(row_pred(OP_BUCK, 30000, 19999, 7000, 1023));
    directed_rows.push_back(row_pred(OP_SOFT_START, 30000, 100, 12000, 1023));
    directed_rows.push_back(row_pred(OP_BOOST, 19999, 40000, 15000, 300));
    directed_rows.push_back(row_pred(OP_IDLE, 65535, 65535, -1, 1023));
    directed_rows.push_back(row_pred(OP_BUCK, 9000, 20001, 32767, 777));
    directed_rows.push_back(row_known(OP_BOOST, 65535, 0, -32768, 1000,
                                      1023, MaskOne, 1, 0, 0, 0, 1000));
    directed_rows.push_back(row_pred(OP_BUCK, 21000, 65535, 25000, 1000));
    directed_rows.push_back(row_pred(OP_SOFT_START, 8999, 0, 10001, 1023));
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].known_valid, directed_rows[i].known);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0:       begin send_idle_pct = 10; stall_pct = 74; end
        1:       begin send_idle_pct = 74; stall_pct = 10; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      apply_config(ph);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        pick = $urandom_range(99);
        if (pick < 30)      kind = BURST_RAMP;
        else if (pick < 55) kind = BURST_BUCK;
        else if (pick < 80) kind = BURST_BOOST;
        else                kind = BURST_NOISE;
        pick = $urandom_range(9);
        if (pick == 0)     burst_lim = $urandom_range(1001, 1023);
        else if (pick < 3) burst_lim = $urandom_range(1023);
        else               burst_lim = $urandom_range(600, 1000);
        burst_len = $urandom_range(4, 24);
        for (int k = 0; k < burst_len && sent < ItemsPerPhase; k++) begin
          send_item(random_item(kind, burst_lim), 1'b0, '0);
          sent++;
          // hold off the sender until the pipeline is empty
          if (ph == 1 && sent == ItemsPerPhase / 2) wait_drained();
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
